// ----- rtl/core/assert_macros.svh -----
// Assertion macros used by the checker file of the deque core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/bcdq_pkg.sv -----
// Package: operation codes, status codes, controller states and control structs.
package bcdq_pkg;

  // Operation codes carried in the func field
  typedef enum logic [2:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_DELETE     = 3'd4,
    FN_FIND       = 3'd5,
    FN_CLEAR      = 3'd6,
    FN_PEEK       = 3'd7
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_MISS = 2'd1,
    STAT_FULL = 2'd2
  } status_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_SEARCH = 2'd1,
    ST_APPLY  = 2'd2,
    ST_REPORT = 2'd3
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;
    logic search;
    logic apply;
    logic report;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

// ----- rtl/core/bcdq_if.sv -----
// Input and result channel interfaces of the deque core.
interface bcdq_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] func;
  logic [7:0] value;

  modport source (output valid, output func, output value, input ready);
  modport sink   (input valid, input func, input value, output ready);
endinterface

interface bcdq_out_if #(
  parameter int CAPACITY = 16
);
  localparam int COUNT_W = $clog2(CAPACITY + 1);

  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [7:0]         data_value;
  logic [COUNT_W-1:0] entry_count;
  logic [7:0]         front_value;
  logic [7:0]         back_value;
  logic               is_empty;

  modport source (output valid, output status, output data_value, output entry_count,
                  output front_value, output back_value, output is_empty, input ready);
  modport sink   (input valid, input status, input data_value, input entry_count,
                  input front_value, input back_value, input is_empty, output ready);
endinterface

// ----- rtl/core/bounded_char_deque_with_search_core.sv -----
// Top level of the bounded byte deque with delete-by-key and search.
// A bounded ordered list of bytes held in a row of register cells. Each input
// transfer carries one operation (push front/back, pop front/back, delete first
// match, find, clear, peek) and yields exactly one result transfer with status,
// removed or found byte, entry count, front and back bytes and an empty flag.
// The result of an operation goes through the steps compare all cells, update
// the cells and register the result, the last of which waits while the result
// register still holds an untaken result; the controller handles one operation
// at a time and takes no new input transfer until the current one is reported,
// and the result register lets the next operation enter while a result still
// waits.
// No clearing pass after reset: the list is empty from the first cycle.
module bounded_char_deque_with_search_core import bcdq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  bcdq_in_if.sink    in_ch,
  bcdq_out_if.source out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Operation sequencer
  bcdq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Cell row and result register
  bcdq_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_func    (in_ch.func),
    .in_value   (in_ch.value),
    .out_ready  (out_ch.ready),
    .out_valid  (out_ch.valid),
    .out_status (out_ch.status),
    .out_data   (out_ch.data_value),
    .out_count  (out_ch.entry_count),
    .out_front  (out_ch.front_value),
    .out_back   (out_ch.back_value),
    .out_empty  (out_ch.is_empty)
  );

endmodule

// ----- rtl/core/bcdq_ctrl.sv -----
// Controller: sequences capture, compare, update and report for one operation.
module bcdq_ctrl import bcdq_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic out_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next  = state;
    cmd         = '0;
    in_ready    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd.search = 1'b1;
        state_next = ST_APPLY;
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_REPORT;
      end
      ST_REPORT: begin
        // wait until the result register is free or being drained
        if (!sts.out_busy || out_ready) begin
          cmd.report = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/core/bcdq_dpath.sv -----
// Datapath: row of byte cells, parallel compare, shift update and result register.
module bcdq_dpath import bcdq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  cmd_t                             cmd,
  output sts_t                             sts,
  input  logic [2:0]                       in_func,
  input  logic [7:0]                       in_value,
  input  logic                             out_ready,
  output logic                             out_valid,
  output logic [1:0]                       out_status,
  output logic [7:0]                       out_data,
  output logic [$clog2(CAPACITY+1)-1:0]    out_count,
  output logic [7:0]                       out_front,
  output logic [7:0]                       out_back,
  output logic                             out_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = $clog2(CAPACITY);

  logic [7:0]          cells [CAPACITY];
  logic [7:0]          cells_next [CAPACITY];
  logic [CW-1:0]       count, count_next;
  func_t               func_r;
  logic [7:0]          value_r;
  logic [CAPACITY-1:0] match_r;
  logic [CAPACITY-1:0] after;
  status_t             status_next;
  logic [7:0]          data_next;
  status_t             status_r;
  logic [7:0]          data_r;
  logic [IW-1:0]       last;
  logic                is_full;
  logic                is_zero;

  assign last    = IW'(count - CW'(1));
  assign is_full = (count == CW'(CAPACITY));
  assign is_zero = (count == '0);
  assign sts.out_busy = out_valid;

  // Operation capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      func_r  <= func_t'(in_func);
      value_r <= in_value;
    end
  end

  // Parallel compare against every occupied cell
  always_ff @(posedge clk) begin
    if (cmd.search) begin
      for (int i = 0; i < CAPACITY; i++) begin
        match_r[i] <= (CW'(i) < count) && (cells[i] == value_r);
      end
    end
  end

  // Cells at or past the first match take their right neighbor on delete
  always_comb begin
    after[0] = match_r[0];
    for (int i = 1; i < CAPACITY; i++) begin
      after[i] = after[i-1] | match_r[i];
    end
  end

  // Next list contents, count, status and data
  always_comb begin
    cells_next  = cells;
    count_next  = count;
    status_next = STAT_OK;
    data_next   = '0;
    unique case (func_r)
      FN_PUSH_FRONT: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          for (int i = 1; i < CAPACITY; i++) begin
            cells_next[i] = cells[i-1];
          end
          cells_next[0] = value_r;
          count_next    = count + CW'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (is_full) begin
          status_next = STAT_FULL;
        end else begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (CW'(i) == count) begin
              cells_next[i] = value_r;
            end
          end
          count_next = count + CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (is_zero) begin
          status_next = STAT_MISS;
        end else begin
          data_next = cells[0];
          for (int i = 0; i < CAPACITY - 1; i++) begin
            cells_next[i] = cells[i+1];
          end
          count_next = count - CW'(1);
        end
      end
      FN_POP_BACK: begin
        if (is_zero) begin
          status_next = STAT_MISS;
        end else begin
          data_next  = cells[last];
          count_next = count - CW'(1);
        end
      end
      FN_DELETE: begin
        if (match_r == '0) begin
          status_next = STAT_MISS;
        end else begin
          data_next = value_r;
          for (int i = 0; i < CAPACITY - 1; i++) begin
            if (after[i]) begin
              cells_next[i] = cells[i+1];
            end
          end
          count_next = count - CW'(1);
        end
      end
      FN_FIND: begin
        if (match_r == '0) begin
          status_next = STAT_MISS;
        end else begin
          data_next = value_r;
        end
      end
      FN_CLEAR: begin
        count_next = '0;
      end
      FN_PEEK: begin
        if (is_zero) begin
          status_next = STAT_MISS;
        end else begin
          data_next = cells[0];
        end
      end
      default: begin
        status_next = STAT_OK;
      end
    endcase
  end

  // List update
  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      cells    <= cells_next;
      status_r <= status_next;
      data_r   <= data_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.apply) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.report) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.report) begin
      out_status <= status_r;
      out_data   <= data_r;
      out_count  <= count;
      out_front  <= is_zero ? 8'd0 : cells[0];
      out_back   <= is_zero ? 8'd0 : cells[last];
      out_empty  <= is_zero;
    end
  end

endmodule

// ----- rtl/core/bcdq_checker.sv -----
// Port-level checker for the deque core and its bind to the top level.
`include "assert_macros.svh"

module bcdq_checker import bcdq_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [1:0]                    status,
  input logic [7:0]                    data_value,
  input logic [$clog2(CAPACITY+1)-1:0] entry_count,
  input logic [7:0]                    front_value,
  input logic [7:0]                    back_value,
  input logic                          is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);

  // A pending result stays offered until its transfer
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid)
  // One operation at a time: no input transfer right after one
  `ASSERT_NEXT(a_one_at_a_time, clk, rst, in_valid && in_ready, !in_ready)
  // Empty flag agrees with the count, and an empty list shows zero ends
  `ASSERT_SAME(a_empty_ends, clk, rst, out_valid,
    (is_empty == (entry_count == '0)) &&
    (!is_empty || (front_value == 8'd0 && back_value == 8'd0)))
  // Count never exceeds the capacity
  `ASSERT_SAME(a_count_bound, clk, rst, out_valid, entry_count <= CW'(CAPACITY))
  // A failed operation returns no data byte
  `ASSERT_SAME(a_fail_no_data, clk, rst, out_valid && status != STAT_OK, data_value == 8'd0)

endmodule

bind bounded_char_deque_with_search_core bcdq_checker #(
  .CAPACITY (CAPACITY)
) u_bcdq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .status      (out_ch.status),
  .data_value  (out_ch.data_value),
  .entry_count (out_ch.entry_count),
  .front_value (out_ch.front_value),
  .back_value  (out_ch.back_value),
  .is_empty    (out_ch.is_empty)
);

// ----- dv/bounded_char_deque_with_search_core_tb.sv -----
// Self-checking testbench for the bounded byte deque core: directed rows, then random traffic.
module bounded_char_deque_with_search_core_tb import bcdq_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CAP = 16;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int RANDOM_ITEMS = 1500;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_MAX = 10;
  localparam int DIRECTED_ROWS = 24;

  // One result as the block reports it
  typedef struct packed {
    status_t            status;
    logic [7:0]         data;
    logic [CNT_W-1:0]   count;
    logic [7:0]         front;
    logic [7:0]         back;
    logic               empty;
  } deque_result_t;

  // Directed stimulus row; a typed row carries its own expected result
  typedef struct {
    func_t         fn;
    logic [7:0]    val;
    int            reps;
    bit            typed;
    deque_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  bcdq_in_if                      in_ch ();
  bcdq_out_if #(.CAPACITY(CAP))   out_ch ();

  bounded_char_deque_with_search_core #(.CAPACITY(CAP)) uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the list
  logic [7:0]     store [CAP];
  int             fill;
  deque_result_t  pending [$];
  int             fault_count;
  int             cycles;
  bit             filling;

  // Front/back extremes, full and empty errors, delete of the frontmost match
  stim_row_t plan [DIRECTED_ROWS] = '{
    '{FN_PEEK,       8'h00,  1, 1'b1, '{STAT_MISS, 8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_POP_FRONT,  8'h00,  1, 1'b1, '{STAT_MISS, 8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_POP_BACK,   8'hFF,  1, 1'b1, '{STAT_MISS, 8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_DELETE,     8'h55,  1, 1'b1, '{STAT_MISS, 8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_FIND,       8'h00,  1, 1'b1, '{STAT_MISS, 8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_PUSH_BACK,  8'hFF,  1, 1'b1, '{STAT_OK,   8'h00,  5'd1, 8'hFF, 8'hFF, 1'b0}},
    '{FN_PUSH_FRONT, 8'h00,  1, 1'b1, '{STAT_OK,   8'h00,  5'd2, 8'h00, 8'hFF, 1'b0}},
    '{FN_FIND,       8'hFF,  1, 1'b1, '{STAT_OK,   8'hFF,  5'd2, 8'h00, 8'hFF, 1'b0}},
    '{FN_PEEK,       8'h33,  1, 1'b1, '{STAT_OK,   8'h00,  5'd2, 8'h00, 8'hFF, 1'b0}},
    '{FN_PUSH_BACK,  8'h10, 14, 1'b0, '0},
    '{FN_PUSH_FRONT, 8'hAA,  1, 1'b1, '{STAT_FULL, 8'h00, 5'd16, 8'h00, 8'h1D, 1'b0}},
    '{FN_PUSH_BACK,  8'hAA,  1, 1'b1, '{STAT_FULL, 8'h00, 5'd16, 8'h00, 8'h1D, 1'b0}},
    '{FN_DELETE,     8'h80,  1, 1'b1, '{STAT_MISS, 8'h00, 5'd16, 8'h00, 8'h1D, 1'b0}},
    '{FN_DELETE,     8'h15,  1, 1'b0, '0},
    '{FN_PUSH_BACK,  8'h00,  1, 1'b0, '0},
    '{FN_DELETE,     8'h00,  1, 1'b0, '0},
    '{FN_FIND,       8'h00,  1, 1'b0, '0},
    '{FN_POP_BACK,   8'h00,  1, 1'b0, '0},
    '{FN_POP_FRONT,  8'h00,  1, 1'b0, '0},
    '{FN_DELETE,     8'h1D,  1, 1'b0, '0},
    '{FN_CLEAR,      8'h77,  1, 1'b1, '{STAT_OK,   8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_POP_BACK,   8'h00,  1, 1'b1, '{STAT_MISS, 8'h00,  5'd0, 8'h00, 8'h00, 1'b1}},
    '{FN_PUSH_FRONT, 8'h5A,  1, 1'b1, '{STAT_OK,   8'h00,  5'd1, 8'h5A, 8'h5A, 1'b0}},
    '{FN_DELETE,     8'h5A,  1, 1'b1, '{STAT_OK,   8'h5A,  5'd0, 8'h00, 8'h00, 1'b1}}
  };

  // Op mix thresholds, indexed by func code: building up vs. draining
  localparam int FILL_CUT  [8] = '{25, 55, 65, 73, 81, 91, 99, 100};
  localparam int DRAIN_CUT [8] = '{8, 18, 38, 56, 76, 89, 98, 100};

  // Close the gap left by removing the entry at pos
  function automatic void drop_entry(int pos);
    int i;
    for (i = pos; i + 1 < fill; i++) store[i] = store[i + 1];
    fill--;
  endfunction

  // Apply one operation to the shadow list and return the result it gives
  function automatic deque_result_t apply_deque_op(func_t fn, logic [7:0] val);
    deque_result_t r;
    int i;
    int pos;
    r = '0;
    r.status = STAT_OK;
    pos = -1;
    case (fn)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (fill >= CAP) begin
          r.status = STAT_FULL;
        end else if (fn == FN_PUSH_FRONT) begin
          for (i = fill; i > 0; i--) store[i] = store[i - 1];
          store[0] = val;
          fill++;
        end else begin
          store[fill] = val;
          fill++;
        end
      end
      FN_POP_FRONT: begin
        if (fill == 0) begin
          r.status = STAT_MISS;
        end else begin
          r.data = store[0];
          drop_entry(0);
        end
      end
      FN_POP_BACK: begin
        if (fill == 0) begin
          r.status = STAT_MISS;
        end else begin
          r.data = store[fill - 1];
          fill--;
        end
      end
      FN_DELETE, FN_FIND: begin
        for (i = 0; i < fill && pos < 0; i++) if (store[i] == val) pos = i;
        if (pos < 0) begin
          r.status = STAT_MISS;
        end else begin
          r.data = val;
          if (fn == FN_DELETE) drop_entry(pos);
        end
      end
      FN_CLEAR: fill = 0;
      default: begin
        if (fill == 0) r.status = STAT_MISS;
        else r.data = store[0];
      end
    endcase
    r.count = CNT_W'(fill);
    r.front = (fill != 0) ? store[0] : 8'h00;
    r.back  = (fill != 0) ? store[fill - 1] : 8'h00;
    r.empty = (fill == 0);
    return r;
  endfunction

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias toward stored bytes and a small alphabet so searches hit and duplicates occur
  function automatic logic [7:0] pick_value();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 40 && fill > 0) return store[$urandom_range(0, fill - 1)];
    if (roll < 70) return 8'($urandom_range(0, 7));
    return 8'($urandom);
  endfunction

  function automatic func_t pick_func();
    int roll;
    int k;
    roll = $urandom_range(0, 99);
    k = 0;
    while (roll >= (filling ? FILL_CUT[k] : DRAIN_CUT[k])) k++;
    return func_t'(k);
  endfunction

  // Offer one operation, hold it until the transfer, then record what it should give
  task automatic send_op(input func_t fn, input logic [7:0] val, input bit quiet,
                         input bit typed, input deque_result_t want);
    int gap;
    deque_result_t model_out;
    gap = quiet ? 0 : pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func  <= fn;
    in_ch.value <= val;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    model_out = apply_deque_op(fn, val);
    pending.push_back(typed ? want : model_out);
  endtask

  // Hold off the sender until every outstanding result is back
  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending.size() != 0) @(posedge clk);
  endtask

  // Clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Reset, then stimulus and the final verdict
  initial begin
    int r;
    int k;
    int n;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.func = FN_PEEK;
    in_ch.value = 8'h00;
    fill = 0;
    filling = 1'b1;
    fault_count = 0;
    foreach (store[i]) store[i] = 8'h00;
    repeat (5) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    for (r = 0; r < DIRECTED_ROWS; r++) begin
      for (k = 0; k < plan[r].reps; k++) begin
        send_op(plan[r].fn, 8'(plan[r].val + k), 1'b0, plan[r].typed, plan[r].want);
      end
    end
    wait_drained();

    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) wait_drained();
      // swing between filling up and draining so both ends get exercised
      if (fill == CAP && $urandom_range(0, 2) == 0) filling = 1'b0;
      else if (fill == 0 && $urandom_range(0, 1) == 0) filling = 1'b1;
      else if ($urandom_range(0, 79) == 0) filling = !filling;
      send_op(pick_func(), pick_value(), ((n / 120) % 4) == 1, 1'b0, '0);
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (fault_count == 0 && pending.size() == 0) begin
      $display("bounded_char_deque_with_search_core_tb: done, clean");
    end else begin
      $display("bounded_char_deque_with_search_core_tb: done, errors");
    end
    $finish;
  end

  // Result side back-pressure, with calm stretches of constant ready
  initial begin
    int hold;
    hold = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else begin
        out_ch.ready <= 1'b1;
        if (((cycles / 400) % 3) != 0 && $urandom_range(0, 99) < 25) hold = pick_gap();
      end
    end
  end

  // Compare each result transfer with the oldest expectation; watchdog
  always @(posedge clk) begin : result_check
    deque_result_t want;
    deque_result_t got;
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bounded_char_deque_with_search_core_tb: done, errors");
      $finish;
    end else if (!rst && out_ch.valid && out_ch.ready) begin
      got.status = status_t'(out_ch.status);
      got.data   = out_ch.data_value;
      got.count  = out_ch.entry_count;
      got.front  = out_ch.front_value;
      got.back   = out_ch.back_value;
      got.empty  = out_ch.is_empty;
      if (pending.size() == 0) begin
        fault_count++;
        if (fault_count <= REPORT_MAX)
          $display("%0t: result transfer with nothing expected: %p", $realtime, got);
      end else begin
        want = pending.pop_front();
        if (got !== want) begin
          fault_count++;
          if (fault_count <= REPORT_MAX)
            $display("%0t: exp/act st %0d/%0d dat %h/%h cnt %0d/%0d fr %h/%h bk %h/%h e %b/%b",
                     $realtime, want.status, got.status, want.data, got.data,
                     want.count, got.count, want.front, got.front,
                     want.back, got.back, want.empty, got.empty);
        end
      end
    end
  end

  initial cycles = 0;

endmodule
